[src/cfdl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossfading delay line package
// Shared widths, function codes, control structs and delay helpers.
// ----------------------------------------------------------------------------
package cfdl_pkg;

   localparam int DEPTH      = 65536;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int SAMPLE_W   = 24;
   localparam int DLY_W      = 16;
   localparam int LEN_W      = 16;
   localparam int MIX_FRAC   = 16;
   localparam int MIX_W      = MIX_FRAC + 1;
   localparam int CMP_W      = (PTR_W > DLY_W) ? PTR_W : DLY_W;
   localparam int DIV_CNT_W  = $clog2(MIX_FRAC + 1);
   localparam int PROD_W     = SAMPLE_W + 1 + MIX_W + 1;

   localparam logic [LEN_W-1:0] FADE_LEN_RESET = LEN_W'(1024);
   localparam logic [MIX_W-1:0] MIX_ONE        = MIX_W'(1) << MIX_FRAC;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_DELAY  = 1'b1;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] count;
      logic [LEN_W-1:0] length;
   } cfdl_div_req_type;

   typedef struct packed {
      logic                done;
      logic [MIX_FRAC-1:0] mix;
   } cfdl_div_rsp_type;

   // Limits a requested delay to the last entry of the ring.
   function automatic logic [DLY_W-1:0] clamp_delay(input logic [DLY_W-1:0] d);
      logic [CMP_W-1:0] d_ext;
      d_ext = CMP_W'(d);
      if (d_ext > CMP_W'(DEPTH - 1)) begin
         return DLY_W'(DEPTH - 1);
      end
      return d;
   endfunction

   // Read pointer that lies the given (already limited) delay behind the write pointer.
   function automatic logic [PTR_W-1:0] delay_ptr(input logic [PTR_W-1:0] wp,
                                                  input logic [DLY_W-1:0] d);
      logic [CMP_W-1:0] d_ext;
      d_ext = CMP_W'(d);
      return wp - d_ext[PTR_W-1:0];
   endfunction

endpackage

[src/crossfading_delay_line.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossfading delay line
// Ring-buffer audio delay whose read point crossfades linearly to a new delay.
// ----------------------------------------------------------------------------
// A delay-set request is taken in the idle state. A sample request passes the
// store write, the registered read of both read pointers and the output without
// a fade, adds a multiply step in the last step of a fade whose mix has reached
// full scale, and otherwise while fading first waits for the mix factor
// count*65536/length from a serial divider that yields one quotient bit per cycle,
// followed by a multiply step. The store is a single 1-write/2-read memory; entries
// never written since reset read as zero by way of a fill flag, so no clearing
// pass runs after reset. The result register lets a new request in while the
// previous sample still waits to be taken.
// ----------------------------------------------------------------------------
module crossfading_delay_line
   import cfdl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic        [DLY_W-1:0]    req_delay_samples,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_wr_en,
   input  logic        [LEN_W-1:0]    csr_wr_data
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_DIV  = 5'b00100,
      S_MUL  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] orp_ff, orp_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic             active_ff, active_in;
   logic [DLY_W-1:0] pending_ff, pending_in;
   logic             full_ff, full_in;
   logic [LEN_W-1:0] fade_len_ff;

   logic             fade_ff, fade_in;
   logic             sat_ff, sat_in;
   logic             new_ok_ff, old_ok_ff;

   logic signed [SAMPLE_W-1:0] rd_new_ff, rd_old_ff;
   logic signed [PROD_W-1:0]   prod_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   logic signed [SAMPLE_W-1:0] store_mem [DEPTH];

   cfdl_div_req_type div_req;
   cfdl_div_rsp_type div_rsp;

   logic                       accept;
   logic                       sample_acc;
   logic [DLY_W-1:0]           req_dly;
   logic [LEN_W:0]             count_inc;
   logic [PTR_W-1:0]           wp_next, rp_next, orp_next;
   logic                       out_load;
   logic signed [SAMPLE_W-1:0] new_val, old_val;
   logic signed [SAMPLE_W:0]   diff;
   logic [MIX_W-1:0]           mix;
   logic signed [SAMPLE_W+1:0] fade_sum;
   logic signed [SAMPLE_W-1:0] result;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign sample_acc = accept && (req_func == FUNC_SAMPLE);
   assign req_dly    = clamp_delay(req_delay_samples);

   assign new_val = new_ok_ff ? rd_new_ff : '0;
   assign old_val = old_ok_ff ? rd_old_ff : '0;
   assign diff    = (SAMPLE_W + 1)'(new_val) - (SAMPLE_W + 1)'(old_val);
   assign mix     = sat_ff ? MIX_ONE : {1'b0, div_rsp.mix};

   // old + floor((new - old) * mix / 2^16), which equals the weighted sum rounded down.
   assign fade_sum = (SAMPLE_W + 2)'(old_val) + (SAMPLE_W + 2)'(prod_ff >>> MIX_FRAC);
   assign result   = fade_ff ? fade_sum[SAMPLE_W-1:0] : new_val;
   assign out_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      orp_in     = orp_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      pending_in = pending_ff;
      full_in    = full_ff;
      fade_in    = fade_ff;
      sat_in     = sat_ff;

      count_inc = {1'b0, count_ff} + (LEN_W + 1)'(1);
      wp_next   = wp_ff + PTR_W'(1);
      rp_next   = rp_ff + PTR_W'(1);
      orp_next  = orp_ff + PTR_W'(1);

      div_req.start  = 1'b0;
      div_req.count  = count_ff;
      div_req.length = fade_len_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_DELAY) begin
                  // A fade past its first sample keeps the request for its end.
                  if ((fade_len_ff != '0) && active_ff && (count_ff != '0)) begin
                     pending_in = req_dly;
                  end else begin
                     pending_in = '0;
                     orp_in     = rp_ff;
                     count_in   = '0;
                     active_in  = 1'b1;
                     rp_in      = delay_ptr(wp_ff, req_dly);
                  end
               end else begin
                  fade_in  = active_ff && (fade_len_ff != '0);
                  sat_in   = count_ff >= fade_len_ff;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            wp_in = wp_next;
            rp_in = rp_next;
            if (wp_ff == PTR_W'(DEPTH - 1)) begin
               full_in = 1'b1;
            end
            if (fade_ff) begin
               orp_in   = orp_next;
               count_in = count_inc[LEN_W-1:0];
               if (count_inc >= {1'b0, fade_len_ff}) begin
                  active_in = 1'b0;
                  if (pending_ff != '0) begin
                     pending_in = '0;
                     orp_in     = rp_next;
                     count_in   = '0;
                     active_in  = 1'b1;
                     rp_in      = delay_ptr(wp_next, pending_ff);
                  end
               end
               if (sat_ff) begin
                  state_in = S_MUL;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         orp_ff       <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         pending_ff   <= '0;
         full_ff      <= 1'b0;
         fade_ff      <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fade_len_ff  <= FADE_LEN_RESET;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         orp_ff       <= orp_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         full_ff      <= full_in;
         fade_ff      <= fade_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fade_len_ff <= csr_wr_data;
         end
      end
   end

   // Sample store: written on acceptance, both read pointers read in the following
   // cycle (S_READ), so the sample just written is already visible to a zero delay.
   always_ff @(posedge clock) begin
      if (sample_acc) begin
         store_mem[wp_ff] <= req_sample_in;
      end
      if (state_ff == S_READ) begin
         rd_new_ff <= store_mem[rp_ff];
         rd_old_ff <= store_mem[orp_ff];
         new_ok_ff <= full_ff || (rp_ff <= wp_ff);
         old_ok_ff <= full_ff || (orp_ff <= wp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         prod_ff <= PROD_W'(diff) * PROD_W'($signed({1'b0, mix}));
      end
      if ((state_ff == S_OUT) && out_load) begin
         rsp_data_ff <= result;
      end
   end

   cfdl_mix_div u_mix_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result appeared outside the output state");

   a_sample_reads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == FUNC_SAMPLE)) |=> (state_ff == S_READ))
      else $error("sample request did not proceed to the store read");

   a_pending_in_fade: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != '0) |-> active_ff)
      else $error("delay request pending with no fade running");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished while not awaited");

endmodule

[src/cfdl_mix_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossfade mix divider
// Restoring divider, one quotient bit per cycle: mix = count * 2^16 / length,
// for count below length.
// ----------------------------------------------------------------------------
module cfdl_mix_div
   import cfdl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfdl_div_req_type div_req,
   output cfdl_div_rsp_type div_rsp
);

   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     div_ff, div_in;
   logic [MIX_FRAC-1:0]  quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic [LEN_W:0] rem_x2;
   logic [LEN_W:0] rem_sub;
   logic           ge;

   always_comb begin
      rem_x2  = {rem_ff, 1'b0};
      rem_sub = rem_x2 - {1'b0, div_ff};
      ge      = rem_x2 >= {1'b0, div_ff};

      rem_in  = rem_ff;
      div_in  = div_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;

      if (div_req.start) begin
         rem_in  = div_req.count;
         div_in  = div_req.length;
         quot_in = '0;
         cnt_in  = DIV_CNT_W'(MIX_FRAC);
      end else if (cnt_ff != '0) begin
         // The remainder stays below the divisor, so the doubled value fits.
         rem_in  = ge ? rem_sub[LEN_W-1:0] : rem_x2[LEN_W-1:0];
         quot_in = {quot_ff[MIX_FRAC-2:0], ge};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.mix  = quot_ff;

endmodule
